// File: sv/motor_current_sense_average_defines.svh
// Assertion macros shared by the motor current sense average RTL
`ifndef MOTOR_CURRENT_SENSE_AVERAGE_DEFINES_SVH
`define MOTOR_CURRENT_SENSE_AVERAGE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MCSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define MCSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mcsa_pkg.sv
// Shared types and constants for the motor current sense average block
package mcsa_pkg;

  localparam int ADC_W       = 12;
  localparam int VREF_W      = 13;
  localparam int RATIO_W     = 16;
  localparam int RES_W       = 16;
  localparam int MA_W        = 29;
  localparam int P1_W        = ADC_W + VREF_W;
  localparam int NUM_W       = P1_W + RATIO_W;
  localparam int DEN_W       = ADC_W + RES_W;
  localparam int CNT_W       = $clog2(NUM_W + 1);
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VREF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RES   = 2'd2;

  localparam logic [VREF_W-1:0]  VREF_RST  = 13'd3300;
  localparam logic [RATIO_W-1:0] RATIO_RST = 16'd2340;
  localparam logic [RES_W-1:0]   RES_RST   = 16'd1500;

  typedef struct packed {
    logic load_sample;
    logic sum_update;
    logic avg_load;
    logic mul1;
    logic mul2;
    logic div_load_ma;
    logic out_load;
  } mcsa_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } mcsa_sts_t;

endpackage

// File: sv/motor_current_sense_average.sv
// Sequence from input accept to m_axis_tvalid: sum update, mean by reciprocal
// multiply, two multiplies, divider load, 41 divide steps and a done check, output load.
// Samples are taken one at a time, only in idle; the milliamp divider makes one bit per cycle.
// A result still waiting on m_axis_tready holds the next one at its output step.
// Reset: async active low; ring reads as zero until first wrap, registers at defaults.
module motor_current_sense_average #(
  parameter int WINDOW    = 64,
  parameter int SAT_LEVEL = 4000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mcsa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mcsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [11:0] adc_sample, [15:12] zero
  input  logic [mcsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [11:0] window_average, [40:12] current_milliamp, [47:41] zero
  output logic [mcsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] saturated
  output logic                             m_axis_tuser
);

  import mcsa_pkg::*;

  mcsa_cmd_t cmd;
  mcsa_sts_t sts;

  mcsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  mcsa_datapath #(
    .WINDOW   (WINDOW),
    .SAT_LEVEL(SAT_LEVEL)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tdata (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// File: sv/mcsa_ram.sv
// Generic single-port RAM with registered read
module mcsa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mcsa_div.sv
// Iterative restoring divider, one quotient bit per cycle
`include "motor_current_sense_average_defines.svh"

module mcsa_div #(
  parameter int DIVIDEND_W = 41,
  parameter int DIVISOR_W  = 28,
  parameter int CNT_W      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  logic [CNT_W-1:0]      steps_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, divisor_q};
  assign diff    = shifted - {1'b0, divisor_q};

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = steps_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

  `MCSA_ASSERT_NEXT(a_start_busy, start_i && (steps_i != '0), busy_o, "divider idle after start")

endmodule

// File: sv/mcsa_datapath.sv
// Datapath: sample ring, running sum, multipliers, divider and output register
`include "motor_current_sense_average_defines.svh"

module mcsa_datapath #(
  parameter int WINDOW    = 64,
  parameter int SAT_LEVEL = 4000
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mcsa_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mcsa_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [mcsa_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  input  mcsa_pkg::mcsa_cmd_t                    cmd_i,
  output mcsa_pkg::mcsa_sts_t                    sts_o,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [mcsa_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                   m_axis_tuser
);

  import mcsa_pkg::*;

  localparam int AW       = $clog2(WINDOW);
  localparam int SUM_W    = $clog2(((1 << ADC_W) - 1) * WINDOW + 1);
  localparam int RECIP_SH = SUM_W + AW;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  // ceil(2^RECIP_SH / WINDOW): exact floor mean over the whole sum range
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  logic [VREF_W-1:0]  vref_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [RES_W-1:0]   res_q;

  logic [ADC_W-1:0] sample_q;
  logic [AW-1:0]    slot_q;
  logic             wrapped_q;
  logic [SUM_W-1:0] sum_q;
  logic [ADC_W-1:0] ram_rdata;
  logic [ADC_W-1:0] old_sample;

  logic [PROD_W-1:0] avg_prod;
  logic [ADC_W-1:0]  avg_q;
  logic [P1_W-1:0]   p1_q;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  num_q;

  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic [CNT_W-1:0] div_steps;
  logic             div_busy;
  logic [NUM_W-1:0] div_quo;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q  <= VREF_RST;
      ratio_q <= RATIO_RST;
      res_q   <= RES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VREF:  vref_q  <= cfg_data_i[VREF_W-1:0];
        CFG_RATIO: ratio_q <= cfg_data_i[RATIO_W-1:0];
        CFG_RES:   res_q   <= cfg_data_i[RES_W-1:0];
        default: ;
      endcase
    end
  end

  mcsa_ram #(
    .WIDTH(ADC_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.sum_update),
    .addr_i (slot_q),
    .wdata_i(sample_q),
    .rdata_o(ram_rdata)
  );

  // slots not yet written since reset read as zero
  assign old_sample = wrapped_q ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      wrapped_q <= 1'b0;
      sum_q     <= '0;
    end else if (cmd_i.sum_update) begin
      sum_q <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
      if (slot_q == AW'(WINDOW - 1)) begin
        slot_q    <= '0;
        wrapped_q <= 1'b1;
      end else begin
        slot_q <= slot_q + AW'(1);
      end
    end
  end

  assign avg_prod = PROD_W'(sum_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= s_axis_tdata[ADC_W-1:0];
    end
    if (cmd_i.avg_load) begin
      avg_q <= avg_prod[RECIP_SH +: ADC_W];
    end
    if (cmd_i.mul1) begin
      p1_q  <= P1_W'(avg_q) * P1_W'(vref_q);
      den_q <= (DEN_W'(res_q) << ADC_W) - DEN_W'(res_q);
    end
    if (cmd_i.mul2) begin
      num_q <= NUM_W'(p1_q) * NUM_W'(ratio_q);
    end
  end

  assign div_start    = cmd_i.div_load_ma;
  assign div_dividend = num_q;
  assign div_divisor  = den_q;
  assign div_steps    = CNT_W'(NUM_W);

  mcsa_div #(
    .DIVIDEND_W(NUM_W),
    .DIVISOR_W (DEN_W),
    .CNT_W     (CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .steps_i   (div_steps),
    .busy_o    (div_busy),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= OUT_TDATA_W'({div_quo[MA_W-1:0], avg_q});
      out_user_q <= avg_q >= ADC_W'(SAT_LEVEL);
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `MCSA_ASSERT_NEXT(a_out_load_valid, cmd_i.out_load, m_axis_tvalid, "result not presented")

endmodule

// File: sv/mcsa_ctrl.sv
// Controller state machine sequencing one sample through the datapath
`include "motor_current_sense_average_defines.svh"

module mcsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  mcsa_pkg::mcsa_sts_t sts_i,
  output mcsa_pkg::mcsa_cmd_t cmd_o
);

  import mcsa_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_READ   = 4'd1;
  localparam logic [3:0] ST_AVG    = 4'd2;
  localparam logic [3:0] ST_MUL1   = 4'd3;
  localparam logic [3:0] ST_MUL2   = 4'd4;
  localparam logic [3:0] ST_LOAD_M = 4'd5;
  localparam logic [3:0] ST_DIV_M  = 4'd6;
  localparam logic [3:0] ST_OUT    = 4'd7;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign s_axis_tready = state_q == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_sample = 1'b1;
          state_d           = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.sum_update = 1'b1;
        state_d          = ST_AVG;
      end
      ST_AVG: begin
        cmd_o.avg_load = 1'b1;
        state_d        = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_LOAD_M;
      end
      ST_LOAD_M: begin
        cmd_o.div_load_ma = 1'b1;
        state_d           = ST_DIV_M;
      end
      ST_DIV_M: begin
        if (!sts_i.div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MCSA_ASSERT_NEXT(a_accept_read, accept, state_q == ST_READ, "accept did not start a read")
  `MCSA_ASSERT_SAME(a_mul_div_idle, state_q == ST_MUL1, !sts_i.div_busy, "divider busy at multiply")

endmodule
